[rtl/ccsg_pkg.sv]
// ----------------------------------------------------------------------------
// Chassis command safety gate - shared definitions
// Request, mode, link and action codes, register map, reset values and the
// packed stream payload layouts.
// ----------------------------------------------------------------------------
package ccsg_pkg;

    // enable / disable requests for e-stop, brake and throttle lock
    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_ENABLE  = 2'd1;
    localparam logic [1:0] REQ_DISABLE = 2'd2;

    // commanded drive mode
    localparam logic [1:0] DRV_IDLE     = 2'd0;
    localparam logic [1:0] DRV_RC       = 2'd1;
    localparam logic [1:0] DRV_OFFBOARD = 2'd2;

    // link source of the command
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_USB   = 2'd1;
    localparam logic [1:0] SRC_RS485 = 2'd2;

    // reported system mode
    localparam logic [1:0] SYS_IDLE       = 2'd0;
    localparam logic [1:0] SYS_RC         = 2'd1;
    localparam logic [1:0] SYS_OFFBOARD   = 2'd2;
    localparam logic [1:0] SYS_BRAKE_HOLD = 2'd3;

    // reported link state
    localparam logic [1:0] LINK_NONE  = 2'd0;
    localparam logic [1:0] LINK_RC    = 2'd1;
    localparam logic [1:0] LINK_USB   = 2'd2;
    localparam logic [1:0] LINK_RS485 = 2'd3;

    // result action
    localparam logic [1:0] ACT_DRIVE = 2'd0;
    localparam logic [1:0] ACT_BRAKE = 2'd1;
    localparam logic [1:0] ACT_ESTOP = 2'd2;

    // status bit positions
    localparam int FLAG_ESTOP    = 0;
    localparam int FLAG_BRAKE    = 1;
    localparam int FLAG_LOCK     = 2;
    localparam int FLAG_OFFBOARD = 3;
    localparam int FLAG_RC_SRC   = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SPEED_GAIN  = 3'd0;
    localparam logic [2:0] REG_TURN_GAIN   = 3'd1;
    localparam logic [2:0] REG_RPM_LIMIT   = 3'd2;
    localparam logic [2:0] REG_CENTER_THR  = 3'd3;
    localparam logic [2:0] REG_LOCK_SPEED  = 3'd4;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [9:0]         RST_SPEED_GAIN = 10'd400;
    localparam logic [9:0]         RST_TURN_GAIN  = 10'd100;
    localparam logic [14:0]        RST_RPM_LIMIT  = 15'd900;
    localparam logic [14:0]        RST_CENTER_THR = 15'd26;
    localparam logic signed [15:0] RST_LOCK_SPEED = 16'sd141;

    // gain * Q8.8 speed fits in 26 signed bits, their sum in 27
    localparam int PROD_W = 26;
    localparam int SUM_W  = PROD_W + 1;

    localparam int CMD_W = 48;
    localparam int RES_W = 48;

    // command item, last field in the lowest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic               cmd_valid;
        logic [1:0]         link_source;
        logic [1:0]         drive_mode;
        logic [1:0]         lock_request;
        logic [1:0]         brake_request;
        logic [1:0]         estop_request;
        logic               estop_now;
        logic signed [15:0] turn_rate;
        logic signed [15:0] fwd_speed;
    } t_cmd;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic [1:0]         link_state;
        logic [1:0]         system_mode;
        logic               estop_cleared;
        logic [1:0]         action;
        logic [4:0]         status_bits;
        logic signed [15:0] right_rpm;
        logic signed [15:0] left_rpm;
    } t_res;

endpackage

[rtl/ccsg_clamp.sv]
// ----------------------------------------------------------------------------
// Chassis command safety gate - wheel rpm scaler
// Divides a Q8.8 mix sum by 256 toward zero and saturates it at +-limit.
// ----------------------------------------------------------------------------
module ccsg_clamp
    import ccsg_pkg::*;
(
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [14:0]             i_limit,
    output logic signed [15:0]      o_rpm
);

    logic [SUM_W-1:0] w_mag;
    logic [SUM_W-9:0] w_whole;
    logic [14:0]      w_sat;

    always_comb begin
        w_mag   = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
        // truncate on the magnitude so the result rounds toward zero
        w_whole = w_mag[SUM_W-1:8];
        if (w_whole > {{(SUM_W-8-15){1'b0}}, i_limit}) begin
            w_sat = i_limit;
        end else begin
            w_sat = w_whole[14:0];
        end
        o_rpm = i_sum[SUM_W-1] ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});
    end

endmodule

[rtl/chassis_command_safety_gate.sv]
// ----------------------------------------------------------------------------
// Chassis command safety gate
// Latches e-stop, centering, brake and throttle lock requests, tracks mode and
// link, and turns drive commands into saturated left/right wheel rpm targets.
// ----------------------------------------------------------------------------
// An accepted request passes the input register, then the result register, on
// its way to the master side.
// Throughput: one request per cycle; the input stalls only when the result
// register is full and not taken.
// Reset (synchronous, active low): latches cleared, mode idle, link none,
// gain/limit registers back to their defaults, both registers emptied.
// ----------------------------------------------------------------------------
module chassis_command_safety_gate
    import ccsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // tdata: fwd_speed, turn_rate, estop_now, estop_request, brake_request,
    //        lock_request, drive_mode, link_source, cmd_valid, zero pad
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CMD_W-1:0]      s_axis_tdata,

    // tdata: left_rpm, right_rpm, status_bits, action, estop_cleared,
    //        system_mode, link_state, zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [RES_W-1:0]      m_axis_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------ config
    logic [9:0]         r_speed_gain;
    logic [9:0]         r_turn_gain;
    logic [14:0]        r_rpm_limit;
    logic [14:0]        r_center_thr;
    logic signed [15:0] r_lock_speed;
    logic [2:0]         w_reg_idx;
    logic               w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain <= RST_SPEED_GAIN;
            r_turn_gain  <= RST_TURN_GAIN;
            r_rpm_limit  <= RST_RPM_LIMIT;
            r_center_thr <= RST_CENTER_THR;
            r_lock_speed <= RST_LOCK_SPEED;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_SPEED_GAIN: r_speed_gain <= pwdata[9:0];
                REG_TURN_GAIN:  r_turn_gain  <= pwdata[9:0];
                REG_RPM_LIMIT:  r_rpm_limit  <= pwdata[14:0];
                REG_CENTER_THR: r_center_thr <= pwdata[14:0];
                REG_LOCK_SPEED: r_lock_speed <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SPEED_GAIN: prdata = {{(APB_DATA_W-10){1'b0}}, r_speed_gain};
            REG_TURN_GAIN:  prdata = {{(APB_DATA_W-10){1'b0}}, r_turn_gain};
            REG_RPM_LIMIT:  prdata = {{(APB_DATA_W-15){1'b0}}, r_rpm_limit};
            REG_CENTER_THR: prdata = {{(APB_DATA_W-15){1'b0}}, r_center_thr};
            REG_LOCK_SPEED: prdata = {{(APB_DATA_W-16){1'b0}}, r_lock_speed};
            default:        prdata = '0;
        endcase
    end

    // --------------------------------------------------------------- handshake
    logic r_s1_v, r_out_v;
    logic w_out_rdy, w_s1_rdy;

    assign w_out_rdy     = !r_out_v || m_axis_tready;
    assign w_s1_rdy      = !r_s1_v || w_out_rdy;
    assign s_axis_tready = w_s1_rdy;

    // ---------------------------------------------------------- stage 1: input
    t_cmd r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy && s_axis_tvalid) begin
            r_cmd <= t_cmd'(s_axis_tdata);
        end
    end

    // ------------------------------------------- latch update and gain products
    logic r_estop, r_need_center, r_brake, r_lock;
    logic [1:0] r_mode, r_link;
    logic n_estop, n_need_center, n_brake, n_lock;
    logic [1:0] n_mode, n_link;

    logic [16:0]              w_mag;
    logic                     w_centered;
    logic                     w_cleared;
    logic [4:0]               w_flags;
    logic [1:0]               w_action;
    logic signed [15:0]       w_v;
    logic signed [PROD_W-1:0] w_prod_a;
    logic signed [PROD_W-1:0] w_prod_b;
    logic                     w_take;

    assign w_take = r_s1_v && w_out_rdy && r_cmd.cmd_valid;

    always_comb begin
        w_mag      = r_cmd.fwd_speed[15] ? 17'(-$signed({r_cmd.fwd_speed[15], r_cmd.fwd_speed}))
                                         : {1'b0, r_cmd.fwd_speed};
        w_centered = w_mag <= {2'b00, r_center_thr};

        n_estop       = r_estop;
        n_need_center = r_need_center;
        n_brake       = r_brake;
        n_lock        = r_lock;
        n_mode        = r_mode;
        n_link        = r_link;
        w_cleared     = 1'b0;
        w_flags       = '0;
        w_action      = ACT_DRIVE;
        w_v           = r_cmd.fwd_speed;

        if (r_cmd.estop_now || r_cmd.estop_request == REQ_ENABLE) begin
            n_estop       = 1'b1;
            n_need_center = 1'b1;
        end else if (r_cmd.estop_request == REQ_DISABLE) begin
            // release only once the stick has come back to center
            if (!r_need_center || w_centered) begin
                n_estop       = 1'b0;
                n_need_center = 1'b0;
                w_cleared     = 1'b1;
            end
        end
        if (w_centered) begin
            n_need_center = 1'b0;
        end

        if (r_cmd.brake_request == REQ_ENABLE) begin
            n_brake = 1'b1;
        end else if (r_cmd.brake_request == REQ_DISABLE) begin
            n_brake = 1'b0;
        end
        if (r_cmd.lock_request == REQ_ENABLE) begin
            n_lock = 1'b1;
        end else if (r_cmd.lock_request == REQ_DISABLE) begin
            n_lock = 1'b0;
        end

        if (n_estop) begin
            w_flags[FLAG_ESTOP] = 1'b1;
            w_flags[FLAG_BRAKE] = 1'b1;
            w_action            = ACT_ESTOP;
            n_mode              = SYS_BRAKE_HOLD;
        end else if (n_brake) begin
            w_flags[FLAG_BRAKE]  = 1'b1;
            w_flags[FLAG_RC_SRC] = (r_cmd.link_source == SRC_NONE);
            w_action             = ACT_BRAKE;
            n_mode               = SYS_BRAKE_HOLD;
        end else begin
            if (n_lock && r_cmd.link_source == SRC_NONE) begin
                w_flags[FLAG_LOCK] = 1'b1;
                w_v                = r_lock_speed;
            end
            case (r_cmd.drive_mode)
                DRV_RC: begin
                    n_mode = SYS_RC;
                end
                DRV_OFFBOARD: begin
                    n_mode                 = SYS_OFFBOARD;
                    w_flags[FLAG_OFFBOARD] = 1'b1;
                end
                default: begin
                    n_mode = SYS_IDLE;
                end
            endcase
            case (r_cmd.link_source)
                SRC_USB: begin
                    n_link = LINK_USB;
                end
                SRC_RS485: begin
                    n_link = LINK_RS485;
                end
                default: begin
                    n_link               = LINK_RC;
                    w_flags[FLAG_RC_SRC] = 1'b1;
                end
            endcase
        end

        w_prod_a = PROD_W'(w_v * $signed({1'b0, r_speed_gain}));
        w_prod_b = PROD_W'(r_cmd.turn_rate * $signed({1'b0, r_turn_gain}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estop       <= 1'b0;
            r_need_center <= 1'b0;
            r_brake       <= 1'b0;
            r_lock        <= 1'b0;
            r_mode        <= SYS_IDLE;
            r_link        <= LINK_NONE;
        end else if (w_take) begin
            r_estop       <= n_estop;
            r_need_center <= n_need_center;
            r_brake       <= n_brake;
            r_lock        <= n_lock;
            r_mode        <= n_mode;
            r_link        <= n_link;
        end
    end

    // ----------------------------------------------------- mix, scale, saturate
    logic signed [SUM_W-1:0] w_sum_l, w_sum_r;
    logic signed [15:0]      w_rpm_l, w_rpm_r;

    assign w_sum_l = SUM_W'(w_prod_a) - SUM_W'(w_prod_b);
    assign w_sum_r = SUM_W'(w_prod_a) + SUM_W'(w_prod_b);

    ccsg_clamp u_clamp_left (
        .i_sum   (w_sum_l),
        .i_limit (r_rpm_limit),
        .o_rpm   (w_rpm_l)
    );

    ccsg_clamp u_clamp_right (
        .i_sum   (w_sum_r),
        .i_limit (r_rpm_limit),
        .o_rpm   (w_rpm_r)
    );

    // --------------------------------------------------------- result register
    t_res r_res;
    t_res n_res;

    always_comb begin
        n_res               = '0;
        n_res.left_rpm      = (w_action == ACT_DRIVE) ? w_rpm_l : '0;
        n_res.right_rpm     = (w_action == ACT_DRIVE) ? w_rpm_r : '0;
        n_res.status_bits   = w_flags;
        n_res.action        = w_action;
        n_res.estop_cleared = w_cleared;
        n_res.system_mode   = n_mode;
        n_res.link_state    = n_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_rdy) begin
            // drop requests flagged invalid
            r_out_v <= r_s1_v && r_cmd.cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_res;

endmodule
